// ----- hw/rtl/fixed_point_alu_core_defines.svh -----
// Assertion macros for the fixed-point ALU.
// Depends on nothing; included by files that carry assertions.
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH

// Same-cycle implication
`define FPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa assertion failed");

// Next-cycle implication
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa assertion failed");

`endif

// ----- hw/rtl/fpa_pkg.sv -----
// Package for the fixed-point ALU: transfer types, command codes, pipeline item
// and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int FPA_FRAC_BITS_DEF = 8;
    localparam int FPA_QB            = 33;  // quotient bits, one per divider stage

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,  CMD_SUB  = 4'd1,  CMD_MUL  = 4'd2,  CMD_DIV  = 4'd3,
        CMD_GT   = 4'd4,  CMD_LT   = 4'd5,  CMD_GE   = 4'd6,  CMD_LE   = 4'd7,
        CMD_EQ   = 4'd8,  CMD_NE   = 4'd9,  CMD_MIN  = 4'd10, CMD_MAX  = 4'd11,
        CMD_INC  = 4'd12, CMD_DEC  = 4'd13, CMD_FINT = 4'd14, CMD_TINT = 4'd15
    } t_cmd;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               divide_by_zero;
    } t_out;

    // Item travelling down the pipeline
    typedef struct packed {
        t_cmd         cmd;
        logic [31:0]  res;
        logic         cmp;
        logic         dz;
        logic         neg;   // quotient sign
        logic         ovf;   // quotient beyond 33 bits
        logic [31:0]  rem;
        logic [32:0]  den;
        logic [32:0]  nlo;   // numerator bits still to bring down
        logic [32:0]  quo;
        logic [63:0]  prod;
    } t_item;

    // Signed 64-bit value clamped to 32 bits
    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude with sign applied, clamped to 32 bits
    function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        logic [63:0] t;
        t = 64'd0 - m;
        if (neg) begin
            r = (m > 64'd2147483648) ? 32'h8000_0000 : t[31:0];
        end else begin
            r = (m > 64'd2147483647) ? 32'h7fff_ffff : m[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/fpa_div_stage.sv -----
// One restoring-division step with its pipeline register.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  fpa_pkg::t_item i_item,
    output logic          o_vld,
    output fpa_pkg::t_item o_item
);
    import fpa_pkg::*;

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic [32:0] w_r2;
    logic        w_ge;

    // Bring down one numerator bit, subtract divisor when it fits
    always_comb begin
        n_item = i_item;
        w_r2   = {i_item.rem, i_item.nlo[32]};
        w_ge   = (w_r2 >= i_item.den);
        n_item.rem = w_ge ? 32'(w_r2 - i_item.den) : w_r2[31:0];
        n_item.nlo = {i_item.nlo[31:0], 1'b0};
        n_item.quo = {i_item.quo[31:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule

// ----- hw/rtl/fixed_point_alu_core.sv -----
// Fixed-point ALU, signed 32-bit raw operands with FRAC_BITS fraction bits.
// Front, rounding, divider, output stages; one item per cycle unless held.
// Depth is set by the divider: 33 restoring steps, one quotient bit per stage.
// A held result freezes the whole pipeline. Synchronous active-low reset
// clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "fixed_point_alu_core_defines.svh"
module fixed_point_alu_core #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  fpa_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output fpa_pkg::t_out o_data
);
    import fpa_pkg::*;

    localparam int          NW   = FRAC_BITS + 34;
    localparam logic [63:0] HALF = 64'((65'd1 << FRAC_BITS) >> 1);

    logic  w_en;
    logic  r_v1, r_v2, r_ovld;
    t_item r_it1, r_it2, n_it1, n_it2;
    t_out  r_out, n_out;
    logic  w_v  [0:FPA_QB];
    t_item w_it [0:FPA_QB];

    // Whole pipeline advances unless the result is held
    assign w_en    = !(r_ovld && i_stall);
    assign o_stall = !w_en;

    // Front stage: simple ops, product, divider set-up
    logic signed [31:0] w_a, w_b;
    logic [31:0]        w_ma, w_mb;
    logic [NW-1:0]      w_num;
    logic [FRAC_BITS:0] w_top;
    always_comb begin
        w_a   = i_data.operand_a;
        w_b   = i_data.operand_b;
        w_ma  = w_a[31] ? 32'(-w_a) : w_a;
        w_mb  = w_b[31] ? 32'(-w_b) : w_b;
        w_num = (NW'(w_ma) << (FRAC_BITS + 1)) + NW'(w_mb);
        w_top = w_num[NW-1:33];
        n_it1      = '0;
        n_it1.cmd  = t_cmd'(i_data.command);
        n_it1.prod = 64'(w_a) * 64'(w_b);
        n_it1.den  = {w_mb, 1'b0};
        n_it1.nlo  = w_num[32:0];
        n_it1.ovf  = (64'(w_top) >= 64'(n_it1.den));
        n_it1.rem  = 32'(w_top);
        n_it1.neg  = w_a[31] ^ w_b[31];
        n_it1.dz   = (n_it1.cmd == CMD_DIV) && (w_b == 32'sd0);
        case (n_it1.cmd)
            CMD_ADD:  n_it1.res = sat64(64'(w_a) + 64'(w_b));
            CMD_SUB:  n_it1.res = sat64(64'(w_a) - 64'(w_b));
            CMD_GT:   n_it1.cmp = (w_a > w_b);
            CMD_LT:   n_it1.cmp = (w_a < w_b);
            CMD_GE:   n_it1.cmp = (w_a >= w_b);
            CMD_LE:   n_it1.cmp = (w_a <= w_b);
            CMD_EQ:   n_it1.cmp = (w_a == w_b);
            CMD_NE:   n_it1.cmp = (w_a != w_b);
            CMD_MIN:  n_it1.res = (w_a < w_b) ? w_a : w_b;
            CMD_MAX:  n_it1.res = (w_a > w_b) ? w_a : w_b;
            CMD_INC:  n_it1.res = sat64(64'(w_a) + 64'sd1);
            CMD_DEC:  n_it1.res = sat64(64'(w_a) - 64'sd1);
            CMD_FINT: n_it1.res = sat64(64'(w_a) <<< FRAC_BITS);
            CMD_TINT: n_it1.res = 32'(w_a >>> FRAC_BITS);
            default:  n_it1.res = '0;  // mul, div filled in later
        endcase
    end

    // Second stage: round the product half away from zero
    logic [63:0] w_pm, w_pr;
    always_comb begin
        n_it2 = r_it1;
        w_pm  = r_it1.prod[63] ? (64'd0 - r_it1.prod) : r_it1.prod;
        w_pr  = (w_pm + HALF) >> FRAC_BITS;
        if (r_it1.cmd == CMD_MUL) begin
            n_it2.res = sat_mag(w_pr, r_it1.prod[63]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it1 <= n_it1;
            r_it2 <= n_it2;
        end
    end

    // Divider chain
    assign w_v[0]  = r_v2;
    assign w_it[0] = r_it2;
    for (genvar g = 0; g < FPA_QB; g++) begin : g_div
        fpa_div_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_v[g]),
            .i_item (w_it[g]),
            .o_vld  (w_v[g+1]),
            .o_item (w_it[g+1])
        );
    end

    // Output stage: quotient sign and saturation
    always_comb begin
        n_out.result_value   = w_it[FPA_QB].res;
        n_out.compare_true   = w_it[FPA_QB].cmp;
        n_out.divide_by_zero = w_it[FPA_QB].dz;
        if (w_it[FPA_QB].cmd == CMD_DIV && !w_it[FPA_QB].dz) begin
            n_out.result_value = sat_mag(w_it[FPA_QB].ovf ? (64'd1 << 40)
                                         : 64'(w_it[FPA_QB].quo), w_it[FPA_QB].neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_v[FPA_QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

    // Terms for the checks below
    logic w_res_zero, w_out_cmp, w_out_dz, w_dz_clean;
    assign w_res_zero = (o_data.result_value == 32'sd0);
    assign w_out_cmp  = o_valid && o_data.compare_true;
    assign w_out_dz   = o_valid && o_data.divide_by_zero;
    assign w_dz_clean = w_res_zero && !o_data.compare_true;

    `FPA_ASSERT_IMPL(a_cmp_zero, i_clk, i_rst_n, w_out_cmp, w_res_zero)
    `FPA_ASSERT_IMPL(a_dz_clean, i_clk, i_rst_n, w_out_dz, w_dz_clean)
    `FPA_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_stall, o_valid)
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the fixed-point ALU core: random and directed commands,
// predicted in-line and compared transfer by transfer. Depends on fpa_pkg and the core.
`timescale 1ns / 1ps
module tb;
    import fpa_pkg::*;

    localparam int FRAC  = FPA_FRAC_BITS_DEF;
    localparam int DRAIN = 80;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  out_stall = 1'b0;
    t_in   in_data = '0;
    logic  blk_stall;
    logic  blk_valid;
    t_out  blk_data;

    t_in   pending_ops[$];
    t_out  expected_res[$];
    int    mismatches = 0;
    bit    feed_done = 1'b0;
    int    hold_cycles = 0;
    int    cyc = 0;
    bit    hold_done = 1'b0;

    fixed_point_alu_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(blk_stall),
        .i_data(in_data), .o_valid(blk_valid), .i_stall(out_stall), .o_data(blk_data)
    );

    always #2 i_clk = ~i_clk;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'h7fff_ffff;
        if (v < -96'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Expected result of one command
    function automatic t_out alu_predict(input t_in op);
        t_out r;
        logic signed [95:0] a, b, p;
        logic [95:0] m, n, d, q;
        logic neg;
        r = '0;
        a = op.operand_a;
        b = op.operand_b;
        case (t_cmd'(op.command))
            CMD_ADD:  r.result_value = clamp32(a + b);
            CMD_SUB:  r.result_value = clamp32(a - b);
            CMD_MUL: begin
                p = a * b;
                neg = p < 0;
                m = neg ? -p : p;
                m = (m + ((96'd1 << FRAC) >> 1)) >> FRAC;
                r.result_value = clamp32(neg ? -$signed(m) : $signed(m));
            end
            CMD_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    n = (a < 0 ? -a : a) << FRAC;
                    d = b < 0 ? -b : b;
                    q = (2 * n + d) / (2 * d);
                    neg = (a < 0) != (b < 0);
                    r.result_value = clamp32(neg ? -$signed(q) : $signed(q));
                end
            end
            CMD_GT:   r.compare_true = a > b;
            CMD_LT:   r.compare_true = a < b;
            CMD_GE:   r.compare_true = a >= b;
            CMD_LE:   r.compare_true = a <= b;
            CMD_EQ:   r.compare_true = a == b;
            CMD_NE:   r.compare_true = a != b;
            CMD_MIN:  r.result_value = a < b ? a[31:0] : b[31:0];
            CMD_MAX:  r.result_value = a > b ? a[31:0] : b[31:0];
            CMD_INC:  r.result_value = clamp32(a + 1);
            CMD_DEC:  r.result_value = clamp32(a - 1);
            CMD_FINT: r.result_value = clamp32(a <<< FRAC);
            default:  r.result_value = op.operand_a >>> FRAC;
        endcase
        return r;
    endfunction

    // Operand biased towards the interesting corners
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return $urandom_range(0, 1023) - 512;
            4: return ($urandom_range(0, 1) ? 1 : -1) * ($urandom_range(0, 256) << FRAC);
            5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    task automatic add_op(input t_cmd c, input logic [31:0] a, input logic [31:0] b);
        t_in op;
        op.command = c;
        op.operand_a = a;
        op.operand_b = b;
        pending_ops.push_back(op);
    endtask

    // Stimulus: directed corners, then random commands
    initial begin
        t_cmd c;
        add_op(CMD_ADD, 32'h7fff_ffff, 32'd1);
        add_op(CMD_SUB, 32'h8000_0000, 32'd1);
        add_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        add_op(CMD_MUL, 32'hffff_ff80, 32'd1);
        add_op(CMD_MUL, 32'd128, 32'd1);
        add_op(CMD_DIV, 32'd5, 32'd0);
        add_op(CMD_DIV, 32'h8000_0000, 32'd1);
        add_op(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
        add_op(CMD_DIV, 32'hffff_ffff, 32'd512);
        add_op(CMD_GT, 32'd3, 32'd3);
        add_op(CMD_LT, 32'h8000_0000, 32'h7fff_ffff);
        add_op(CMD_GE, 32'd3, 32'd3);
        add_op(CMD_LE, 32'd4, 32'd3);
        add_op(CMD_EQ, 32'hffff_ffff, 32'hffff_ffff);
        add_op(CMD_NE, 32'd0, 32'd0);
        add_op(CMD_MIN, 32'h8000_0000, 32'h7fff_ffff);
        add_op(CMD_MAX, 32'h8000_0000, 32'h7fff_ffff);
        add_op(CMD_INC, 32'h7fff_ffff, 32'd0);
        add_op(CMD_DEC, 32'h8000_0000, 32'd0);
        add_op(CMD_FINT, 32'h0080_0000, 32'd0);
        add_op(CMD_FINT, 32'hff7f_ffff, 32'd0);
        add_op(CMD_TINT, 32'hffff_ffff, 32'd0);
        add_op(CMD_TINT, 32'h7fff_ffff, 32'hffff_ffff);
        repeat (1200) begin
            c = t_cmd'($urandom_range(0, 15));
            add_op(c, rand_operand(), rand_operand());
        end
        feed_done = 1'b1;
    end

    // Reset, then wait for the last expected transfer
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (feed_done && pending_ops.size() == 0 && !in_valid && expected_res.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    // Driver: one transfer per accepted cycle, idling apart from a quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !blk_stall) begin
            if (in_valid) expected_res.push_back(alu_predict(in_data));
            if (pending_ops.size() != 0 && (cyc > 1500 && cyc < 2500 ||
                    $urandom_range(0, 99) >= 13)) begin
                in_data <= pending_ops.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, plus one long hold-off to back up the pipeline
    always @(posedge i_clk) begin
        if (!hold_done && cyc == 400) begin
            hold_cycles <= 300;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= hold_cycles > 1;
        end else if (cyc > 1500 && cyc < 2500) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= $urandom_range(0, 99) < 13;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && blk_valid && !out_stall) begin
            if (expected_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", blk_data);
            end else begin
                exp_r = expected_res.pop_front();
                if (blk_data.result_value !== exp_r.result_value ||
                        blk_data.compare_true !== exp_r.compare_true ||
                        blk_data.divide_by_zero !== exp_r.divide_by_zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp val %h cmp %b dz %b, got val %h cmp %b dz %b",
                                 exp_r.result_value, exp_r.compare_true, exp_r.divide_by_zero,
                                 blk_data.result_value, blk_data.compare_true,
                                 blk_data.divide_by_zero);
                end
            end
        end
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_div_stage.sv
hw/rtl/fixed_point_alu_core.sv
verif/tb.sv
